[design/iirdf_pkg.sv]
// iirdf_pkg: types and constants shared by the direct-form-I iir filter
// payload structs, fixed-point widths and configuration register indexes
// no dependencies
package iirdf_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;
  localparam int FRAC_BITS    = 14;
  localparam int CFG_IDX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_3 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEN_COEF_1 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEN_COEF_2 = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEN_COEF_3 = 3'd6;

  // reset value of b0: 1.0 in q2.14
  localparam logic signed [COEF_BITS-1:0] NUM_COEF_0_RESET = 16'sd16384;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;
  } out_item_t;

endpackage

[design/iir_filter_direct_form.sv]
// iir_filter_direct_form: direct-form-I iir filter, order 1 to 3, q2.14 coefficients
// depends on iirdf_pkg for payload types, widths and register indexes
//
// One request in gives one result out. Each sample x[n] produces
//   y[n] = b0*x[n] + b1*x[n-1] + .. + bN*x[n-N] - a1*y[n-1] - .. - aN*y[n-N]
// with N = ORDER. Coefficients are signed q2.14 (16384 = 1.0), already scaled by a0.
// The exact sum is rounded to nearest (ties toward +inf), saturated to 16 bits, and
// clipped is set when saturation changed the value. The saturated value is what
// enters the output history. restart clears both histories before its own sample.
// Rate: one sample per cycle while the output does not stall; each sample passes
// through the input register, then the result register. The rate is set by the
// feedback loop: all multiplies, the sum, rounding and saturation of one sample
// are combinational, so that y[n] is in the history for the next sample. The input
// register, if empty, takes a request while a finished result waits on a stalled output.
// Registers: 0..3 num_coef_0..3 (b0..b3), 4..6 den_coef_1..3 (a1..a3). Writes to
// taps above ORDER and to index 7 are dropped; write only while the block is idle.
module iir_filter_direct_form #(
  parameter int ORDER = 3  // 1 to 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  iirdf_pkg::in_item_t                   in_item,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output iirdf_pkg::out_item_t                  out_item,
  // configuration port
  input  logic                                  cfg_wr_en,
  input  logic [iirdf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [iirdf_pkg::COEF_BITS-1:0]       cfg_wdata
);
  import iirdf_pkg::*;

  // widths of the datapath
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(2 * ORDER + 1) + 1;  // room for all terms
  localparam int Y_W    = ACC_W - FRAC_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  // coefficient registers, only the taps in use are stored
  logic signed [COEF_BITS-1:0] num_coef_r [0:ORDER];
  logic signed [COEF_BITS-1:0] den_coef_r [1:ORDER];

  // histories: entry k holds x[n-1-k] and y[n-1-k]
  logic signed [SAMPLE_BITS-1:0] past_in_r  [0:ORDER-1];
  logic signed [SAMPLE_BITS-1:0] past_out_r [0:ORDER-1];

  // input register and result register
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  // histories seen by the current sample, zero on restart
  logic signed [SAMPLE_BITS-1:0] hx [0:ORDER-1];
  logic signed [SAMPLE_BITS-1:0] hy [0:ORDER-1];

  logic signed [PROD_W-1:0]      prod_b [0:ORDER];
  logic signed [PROD_W-1:0]      prod_a [1:ORDER];
  logic signed [ACC_W-1:0]       acc;
  logic signed [Y_W-1:0]         y_full;
  logic [Y_W-SAMPLE_BITS:0]      y_top;
  logic signed [SAMPLE_BITS-1:0] filtered_nxt;
  logic                          clipped_nxt;

  logic advance;   // result register free or being emptied this cycle
  logic in_take;   // request accepted this cycle

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // multiply-accumulate for the sample in the input register
  always_comb begin
    for (int k = 0; k < ORDER; k++) begin
      hx[k] = in_item_r.restart ? '0 : past_in_r[k];
      hy[k] = in_item_r.restart ? '0 : past_out_r[k];
    end
    prod_b[0] = PROD_W'(num_coef_r[0]) * PROD_W'(in_item_r.sample);
    for (int k = 1; k <= ORDER; k++) begin
      prod_b[k] = PROD_W'(num_coef_r[k]) * PROD_W'(hx[k-1]);
      prod_a[k] = PROD_W'(den_coef_r[k]) * PROD_W'(hy[k-1]);
    end
    acc = ACC_W'(prod_b[0]);
    for (int k = 1; k <= ORDER; k++) begin
      acc = acc + ACC_W'(prod_b[k]) - ACC_W'(prod_a[k]);
    end
  end

  // round to nearest, ties up, then saturate
  always_comb begin
    y_full = Y_W'((acc + RND_HALF) >>> FRAC_BITS);
    y_top  = y_full[Y_W-1:SAMPLE_BITS-1];
    if ((&y_top) || !(|y_top)) begin
      filtered_nxt = y_full[SAMPLE_BITS-1:0];
      clipped_nxt  = 1'b0;
    end else begin
      filtered_nxt = y_full[Y_W-1] ? Y_MIN : Y_MAX;
      clipped_nxt  = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ORDER; k++) begin
        num_coef_r[k] <= (k == 0) ? NUM_COEF_0_RESET : '0;
      end
      for (int k = 1; k <= ORDER; k++) begin
        den_coef_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      for (int k = 0; k <= ORDER; k++) begin
        if (cfg_index == REG_NUM_COEF_0 + CFG_IDX_BITS'(k)) begin
          num_coef_r[k] <= $signed(cfg_wdata);
        end
      end
      for (int k = 1; k <= ORDER; k++) begin
        if (cfg_index == REG_DEN_COEF_1 + CFG_IDX_BITS'(k - 1)) begin
          den_coef_r[k] <= $signed(cfg_wdata);
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_item_r.filtered <= filtered_nxt;
      out_item_r.clipped  <= clipped_nxt;
    end
  end

  // history shift, the saturated output goes into the feedback line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDER; k++) begin
        past_in_r[k]  <= '0;
        past_out_r[k] <= '0;
      end
    end else if (advance && in_valid_r) begin
      past_in_r[0]  <= in_item_r.sample;
      past_out_r[0] <= filtered_nxt;
      for (int k = 1; k < ORDER; k++) begin
        past_in_r[k]  <= hx[k-1];
        past_out_r[k] <= hy[k-1];
      end
    end
  end

  // a clipped result sits at one of the two rails
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.clipped) |->
      (out_item_r.filtered == Y_MAX || out_item_r.filtered == Y_MIN))
    else $error("clipped result not at a rail");

  // a waiting result is the newest entry of the output history
  a_hist_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (past_out_r[0] == out_item_r.filtered))
    else $error("output history out of step with result");

  // a stalled result freezes the feedback line
  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(past_out_r[0]) && $stable(past_in_r[0]))
    else $error("history moved while result stalled");

  // a sample in the input register moves into a free result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && advance) |=> out_valid_r)
    else $error("sample lost between input and result register");

endmodule

[sim/iir_filter_direct_form_test.sv]
`timescale 1ns / 1ps
// iir_filter_direct_form_test: self-checking bench for the direct-form-I iir filter
// drives random and corner-case samples through coefficient sets, predicts each output
// depends on iirdf_pkg and iir_filter_direct_form
module iir_filter_direct_form_test;
  import iirdf_pkg::*;

  // index 7 has no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;
  localparam int GAP_PERCENT = 21;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_REQS = 80;

  // coefficient set shapes for the random phases
  typedef enum int {SET_GENTLE, SET_FULL, SET_EXTREME, SET_FIR} coef_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0] cfg_wdata = '0;

  // requests waiting to be offered, head is the one on the bus
  in_item_t pending_samples[$];
  // outputs worked out for accepted requests, oldest first
  out_item_t predicted_outputs[$];
  // request taken at the last rising edge
  logic in_fire = 1'b0;
  // set for the stretch where neither side pauses
  logic no_gaps = 1'b0;
  int mismatch_count = 0;

  // shadow coefficients and filter histories
  logic signed [COEF_BITS-1:0] num_tap[0:3] = '{NUM_COEF_0_RESET, 16'sd0, 16'sd0, 16'sd0};
  logic signed [COEF_BITS-1:0] den_tap[1:3] = '{16'sd0, 16'sd0, 16'sd0};
  logic signed [SAMPLE_BITS-1:0] x_hist[0:2] = '{16'sd0, 16'sd0, 16'sd0};
  logic signed [SAMPLE_BITS-1:0] y_hist[0:2] = '{16'sd0, 16'sd0, 16'sd0};

  iir_filter_direct_form DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // one filter step: exact wide sum, round half up, saturate, then shift histories
  function automatic out_item_t filter_sample(input in_item_t req);
    longint acc;
    longint y;
    logic signed [SAMPLE_BITS-1:0] x;
    out_item_t res;
    x = req.sample;
    if (req.restart) begin
      for (int k = 0; k < 3; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
    end
    acc = longint'(num_tap[0]) * longint'(x);
    for (int k = 1; k <= 3; k++) begin
      acc += longint'(num_tap[k]) * longint'(x_hist[k-1]);
      acc -= longint'(den_tap[k]) * longint'(y_hist[k-1]);
    end
    y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.clipped = 1'b0;
    if (y > SAT_MAX) begin
      y = SAT_MAX;
      res.clipped = 1'b1;
    end else if (y < SAT_MIN) begin
      y = SAT_MIN;
      res.clipped = 1'b1;
    end
    res.filtered = y[SAMPLE_BITS-1:0];
    for (int k = 2; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = res.filtered;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // input side: hold a stalled request, otherwise offer the next one or pause
  always @(negedge clk) begin
    logic drive;
    if (rst_n) begin
      if (in_fire)
        pending_samples.delete(0);
      if (in_valid && !in_fire)
        drive = 1'b1;
      else
        drive = pending_samples.size() != 0 &&
                (no_gaps || $urandom_range(99) >= GAP_PERCENT);
      in_valid <= drive;
      if (drive)
        in_item <= pending_samples[0];
    end
  end

  // output side: random back-pressure
  always @(negedge clk) begin
    if (rst_n)
      out_stall <= !no_gaps && $urandom_range(99) < GAP_PERCENT;
  end

  // check each result against the oldest prediction, then predict for a new request
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = predicted_outputs.pop_front();
          if (out_item.filtered !== want.filtered)
            report_mismatch($sformatf("filtered got %0d want %0d",
                                      $signed(out_item.filtered), $signed(want.filtered)));
          if (out_item.clipped !== want.clipped)
            report_mismatch($sformatf("clipped got %b want %b",
                                      out_item.clipped, want.clipped));
        end
      end
      if (in_valid && !in_stall)
        predicted_outputs.push_back(filter_sample(in_item));
    end
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // single register write, shadow copy follows the same index decode
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_NUM_COEF_0: num_tap[0] = val;
      REG_NUM_COEF_1: num_tap[1] = val;
      REG_NUM_COEF_2: num_tap[2] = val;
      REG_NUM_COEF_3: num_tap[3] = val;
      REG_DEN_COEF_1: den_tap[1] = val;
      REG_DEN_COEF_2: den_tap[2] = val;
      REG_DEN_COEF_3: den_tap[3] = val;
      default: ;
    endcase
  endtask

  // all seven coefficients, plus a junk write to the empty index
  task automatic load_coefs(input logic [15:0] b0, b1, b2, b3, a1, a2, a3);
    write_reg(REG_NUM_COEF_0, b0);
    write_reg(REG_NUM_COEF_1, b1);
    write_reg(REG_NUM_COEF_2, b2);
    write_reg(REG_NUM_COEF_3, b3);
    write_reg(REG_DEN_COEF_1, a1);
    write_reg(REG_DEN_COEF_2, a2);
    write_reg(REG_DEN_COEF_3, a3);
    write_reg(REG_UNUSED, 16'($urandom));
  endtask

  // wait until every request is taken and answered, then give the pipeline a margin
  task automatic drain();
    while (pending_samples.size() != 0 || predicted_outputs.size() != 0 || in_valid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_req(input logic [15:0] s, input logic rs);
    in_item_t req;
    req.sample = s;
    req.restart = rs;
    pending_samples.push_back(req);
  endtask

  function automatic logic [15:0] pick_coef(input coef_shape_t shape, input logic feedback);
    case (shape)
      SET_GENTLE:  return 16'($signed($urandom_range(8192)) - 4096);
      SET_EXTREME: begin
        case ($urandom_range(2))
          0: return 16'h7fff;
          1: return 16'h8000;
          default: return 16'h0000;
        endcase
      end
      SET_FIR:     return feedback ? 16'h0000 : 16'($urandom);
      default:     return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70)
      return 16'($urandom);
    if (roll < 85)
      return 16'($signed($urandom_range(512)) - 256);
    case ($urandom_range(4))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0001;
      3: return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  initial begin
    coef_shape_t shape;
    int calm_phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset coefficients pass samples straight through: full-scale corners
    add_req(16'h7fff, 1'b1);
    add_req(16'h8000, 1'b0);
    add_req(16'h0000, 1'b0);
    add_req(16'h0001, 1'b0);
    add_req(16'hffff, 1'b0);
    drain();

    // gain just under 2.0: both rails clip, small values do not
    load_coefs(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_req(16'h7fff, 1'b0);
    add_req(16'h8000, 1'b0);
    add_req(16'h0064, 1'b0);
    drain();

    // gain 0.5: odd samples land on exact halves, which round up
    load_coefs(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_req(16'h0001, 1'b0);
    add_req(16'hffff, 1'b0);
    add_req(16'h0003, 1'b0);
    add_req(16'hfffd, 1'b0);
    drain();

    // every tap at -2.0 with feedback: saturation fed back into history, then restart
    load_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_req(16'h8000, 1'b1);
    add_req(16'h7fff, 1'b0);
    add_req(16'h0001, 1'b0);
    add_req(16'h0005, 1'b1);
    add_req(16'h0000, 1'b0);
    drain();

    // every tap at just under +2.0, restart in the middle of a running history
    load_coefs(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_req(16'h0010, 1'b0);
    add_req(16'hfff0, 1'b0);
    add_req(16'h0010, 1'b1);
    add_req(16'h0000, 1'b0);
    drain();

    // random phases, each with its own coefficient set; one runs without any pauses
    calm_phase = $urandom_range(RANDOM_PHASES - 1);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      shape = coef_shape_t'(p % 4);
      load_coefs(pick_coef(shape, 1'b0), pick_coef(shape, 1'b0), pick_coef(shape, 1'b0),
                 pick_coef(shape, 1'b0), pick_coef(shape, 1'b1), pick_coef(shape, 1'b1),
                 pick_coef(shape, 1'b1));
      no_gaps = (p == calm_phase);
      for (int i = 0; i < PHASE_REQS; i++)
        add_req(pick_sample(), $urandom_range(99) < 3);
      drain();
      no_gaps = 1'b0;
    end

    // back to unity gain so the last setting is a plain one
    load_coefs(NUM_COEF_0_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 20; i++)
      add_req(pick_sample(), $urandom_range(99) < 3);
    drain();
    repeat (10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule
